FILE: rtl/core/wtk_pkg.sv
`timescale 1ns / 1ps
// shared constants, byte classes and control struct of the word tokenizer
// no dependencies; imported by wtk_scan and the top level

package wtk_pkg;

    // word buffer sizing
    localparam int WORD_MAX = 32;
    localparam int LEN_W    = $clog2(WORD_MAX + 1);
    localparam int IDX_W    = $clog2(WORD_MAX);

    // special bytes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;

    // scanner mode, one-hot
    typedef enum logic [2:0] {
        S_SPACE = 3'b001,
        S_WORD  = 3'b010,
        S_DIGIT = 3'b100
    } t_mode;

    // control from the scanner to the cell row
    typedef struct packed {
        logic             append;
        logic [IDX_W-1:0] wr_idx;
        logic [7:0]       wr_char;
        logic             emit;
        logic [LEN_W-1:0] emit_len;
        logic             emit_trunc;
    } t_buf_ctrl;

    function automatic logic is_letter(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {CH_SPACE, [8'h09:8'h0D]};
    endfunction

endpackage

FILE: rtl/core/wtk_cell.sv
`timescale 1ns / 1ps
// one cell of the word buffer row: a stored character and an output stage
// uses no package items; instantiated by the top level

module wtk_cell (
    input  logic       i_clk,
    input  logic       i_wr_en,
    input  logic [7:0] i_wr_char,
    input  logic       i_load,
    input  logic       i_shift,
    input  logic [7:0] i_next_out,
    output logic [7:0] o_out
);

    logic [7:0] r_word;
    logic [7:0] r_out;

    // character gathered for the word being built
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_word <= i_wr_char;
        end
    end

    // output stage: snapshot of the word, then shift toward cell zero
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_out <= r_word;
        end else if (i_shift) begin
            r_out <= i_next_out;
        end
    end

    assign o_out = r_out;

endmodule

FILE: rtl/core/wtk_scan.sv
`timescale 1ns / 1ps
// byte scanner: hyphen lookahead, line skipping and the space/word/digit mode machine
// depends on wtk_pkg; drives the cell row of the top level

module wtk_scan (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_char,
    input  logic               i_eoi,
    output wtk_pkg::t_buf_ctrl o_ctrl
);
    import wtk_pkg::*;

    t_mode            r_mode, n_mode;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_ovf, n_ovf;
    logic             r_hp, n_hp;
    logic             r_sk, n_sk;
    logic             r_tu, n_tu;

    logic             do1, do2;
    logic [7:0]       b2;
    t_mode            mode1;
    logic             emit1, emit2, clr2, app2;
    logic             clr;
    logic [LEN_W-1:0] len_a;
    logic             ovf_a;
    logic             wr;

    // hyphen lookahead and line skipping decide which bytes get scanned
    always_comb begin
        n_hp = r_hp;
        n_sk = r_sk;
        n_tu = r_tu;
        do1  = 1'b0;
        do2  = 1'b0;
        b2   = i_char;
        if (i_accept) begin
            if (i_eoi) begin
                do1  = r_hp | r_sk | r_tu;
                do2  = 1'b1;
                b2   = CH_SPACE;
                n_hp = 1'b0;
                n_sk = 1'b0;
                n_tu = 1'b0;
            end else if (i_char != CH_NUL) begin
                if (r_sk) begin
                    if (i_char == CH_LF) begin
                        n_sk = 1'b0;
                        n_tu = 1'b1;
                    end
                end else if (r_tu) begin
                    n_tu = 1'b0;
                    do2  = 1'b1;
                end else if (r_hp && is_space(i_char)) begin
                    n_hp = 1'b0;
                    if (i_char == CH_LF) begin
                        n_tu = 1'b1;
                    end else begin
                        n_sk = 1'b1;
                    end
                end else begin
                    do1 = r_hp;
                    if (i_char == CH_HYPHEN) begin
                        n_hp = 1'b1;
                    end else begin
                        n_hp = 1'b0;
                        do2  = 1'b1;
                    end
                end
            end
        end
    end

    // first scan: a held hyphen, which only ends a word in progress
    always_comb begin
        emit1 = do1 && (r_mode == S_WORD);
        mode1 = emit1 ? S_SPACE : r_mode;
    end

    // second scan: the byte itself
    always_comb begin
        n_mode = mode1;
        emit2  = 1'b0;
        clr2   = 1'b0;
        app2   = 1'b0;
        if (do2) begin
            case (mode1)
                S_WORD: begin
                    if (is_letter(b2) || b2 == CH_APOS || b2 == CH_QUOTE) begin
                        app2 = 1'b1;
                    end else if (is_digit(b2)) begin
                        n_mode = S_DIGIT;
                    end else begin
                        n_mode = S_SPACE;
                        emit2  = 1'b1;
                    end
                end
                S_DIGIT: begin
                    if (is_space(b2)) begin
                        n_mode = S_SPACE;
                        clr2   = 1'b1;
                    end
                end
                default: begin
                    if (is_letter(b2)) begin
                        n_mode = S_WORD;
                        clr2   = 1'b1;
                        app2   = 1'b1;
                    end else if (is_digit(b2)) begin
                        n_mode = S_DIGIT;
                        clr2   = 1'b1;
                    end
                end
            endcase
        end
    end

    // length and overflow bookkeeping
    always_comb begin
        clr   = emit1 | emit2 | clr2;
        len_a = clr ? '0 : r_len;
        ovf_a = clr ? 1'b0 : r_ovf;
        wr    = app2 && (len_a < LEN_W'(WORD_MAX));
        n_len = len_a;
        n_ovf = ovf_a;
        if (wr) begin
            n_len = len_a + LEN_W'(1);
        end else if (app2) begin
            n_ovf = 1'b1;
        end
    end

    always_comb begin
        o_ctrl.append     = wr;
        o_ctrl.wr_idx     = len_a[IDX_W-1:0];
        o_ctrl.wr_char    = b2;
        o_ctrl.emit       = emit1 | emit2;
        o_ctrl.emit_len   = r_len;
        o_ctrl.emit_trunc = r_ovf;
    end

    // scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= S_SPACE;
            r_len  <= '0;
            r_ovf  <= 1'b0;
            r_hp   <= 1'b0;
            r_sk   <= 1'b0;
            r_tu   <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_len  <= n_len;
            r_ovf  <= n_ovf;
            r_hp   <= n_hp;
            r_sk   <= n_sk;
            r_tu   <= n_tu;
        end
    end

`ifndef SYNTHESIS
    // overflow only ever follows a full buffer
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_len == LEN_W'(WORD_MAX)))
        else $error("overflow flag set with buffer not full");

    // a word is handed out only with at least one character
    a_emit_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.emit |-> (r_len != '0))
        else $error("empty word emitted");

    // line skipping never coexists with a pending hyphen or a pending line turn
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_sk && r_hp) && !(r_sk && r_tu))
        else $error("conflicting hyphen join flags");
`endif

endmodule

FILE: rtl/core/word_tokenizer_with_hyphen_join.sv
`timescale 1ns / 1ps
// word tokenizer with hyphen join: scanner plus a row of WORD_MAX buffer cells
// first character of a word is presented in the cycle after the byte that ends it
// throughput: one byte per cycle while no word drains; input stalls until a finished word has drained
// the drain is set by the output shift along the cell row, one character per cycle while i_m_tready is high
// reset: synchronous active-low i_rst_n clears scanner mode, flags, length and drain count
// depends on wtk_pkg, wtk_scan and wtk_cell

module word_tokenizer_with_hyphen_join (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] char_code
    input  logic       i_s_tlast,   // end_of_input
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] word_char
    output logic       o_m_tlast,   // word_last
    output logic       o_m_tuser    // [0] word_truncated
);
    import wtk_pkg::*;

    t_buf_ctrl        ctrl;
    logic             s_acc;
    logic             m_acc;
    logic [LEN_W-1:0] r_cnt, n_cnt;
    logic             r_trunc, n_trunc;
    logic [7:0]       w_out [WORD_MAX];

    assign o_s_tready = (r_cnt == '0);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign m_acc      = o_m_tvalid && i_m_tready;

    wtk_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_acc),
        .i_char   (i_s_tdata),
        .i_eoi    (i_s_tlast),
        .o_ctrl   (ctrl)
    );

    // row of buffer cells, output taken from cell zero
    for (genvar gi = 0; gi < WORD_MAX; gi++) begin : g_cell
        logic [7:0] next_out;
        if (gi == WORD_MAX - 1) begin : g_tail
            assign next_out = '0;
        end else begin : g_mid
            assign next_out = w_out[gi+1];
        end
        wtk_cell u_cell (
            .i_clk      (i_clk),
            .i_wr_en    (ctrl.append && (ctrl.wr_idx == IDX_W'(gi))),
            .i_wr_char  (ctrl.wr_char),
            .i_load     (ctrl.emit),
            .i_shift    (m_acc),
            .i_next_out (next_out),
            .o_out      (w_out[gi])
        );
    end

    // drain count of the word being sent
    always_comb begin
        n_cnt   = r_cnt;
        n_trunc = r_trunc;
        if (ctrl.emit) begin
            n_cnt   = ctrl.emit_len;
            n_trunc = ctrl.emit_trunc;
        end else if (m_acc) begin
            n_cnt = r_cnt - LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_trunc <= n_trunc;
    end

    // output word
    assign o_m_tvalid = (r_cnt != '0);
    assign o_m_tdata  = w_out[0];
    assign o_m_tlast  = (r_cnt == LEN_W'(1));
    assign o_m_tuser  = r_trunc;

`ifndef SYNTHESIS
    // a finished word starts draining on the next cycle
    a_emit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.emit |=> (o_m_tvalid && r_cnt == $past(ctrl.emit_len)))
        else $error("emitted word not presented");

    // input reopens right after the last character is taken
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_acc && o_m_tlast) |=> o_s_tready)
        else $error("input not reopened after word end");

    // drain count stays within the buffer depth
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= LEN_W'(WORD_MAX))
        else $error("drain count beyond buffer depth");
`endif

endmodule
